FILE: rtl/ordered_value_list_macros.svh
// ----------------------------------------------------------------------------
// ordered_value_list assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define OVL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_value_list: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define OVL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_value_list: next-cycle check failed");
`else
`define OVL_ASSERT_NOW(label, clk, rst, ante, cons)
`define OVL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// Sizes, field types, action and status codes for the ordered value list.
// ----------------------------------------------------------------------------
package ovl_pkg;

  // store size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int POS_W  = 6;
  localparam int OCNT_W = 7;
  localparam int IN_W   = ((ACT_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_W  = ((ST_W + POS_W + OCNT_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [POS_W-1:0]  pos_field_t;
  typedef logic [OCNT_W-1:0] cnt_field_t;

  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam cnt_t CNT_FULL = cnt_t'(CAPACITY);

  // action codes
  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_SEARCH = 2'd2;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  // controls broadcast from the top level to every cell
  typedef struct packed {
    logic   capture;    // latch compare result this cycle
    logic   append;     // write app_value at index == count
    cnt_t   count;      // entries currently held
    value_t cmp_value;  // value to compare against
    value_t app_value;  // value to append
  } cell_ctl_t;

endpackage

FILE: rtl/ovl_cell.sv
// ----------------------------------------------------------------------------
// ovl_cell
// One list entry: holds a value, flags an equal compare, shifts down or loads.
// ----------------------------------------------------------------------------
module ovl_cell (
  input  logic                clk,
  input  ovl_pkg::cell_ctl_t  ctl,
  input  ovl_pkg::idx_t       idx,       // fixed position of this cell
  input  logic                shift_en,  // take the upper neighbor's value
  input  ovl_pkg::value_t     neighbor,  // value of cell idx+1
  output ovl_pkg::value_t     entry,
  output logic                match
);

  ovl_pkg::cnt_t idx_ext;
  logic          held;

  assign idx_ext = ovl_pkg::cnt_t'(idx);
  assign held    = idx_ext < ctl.count;

  // compare flag, only for entries inside the list
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= held && (entry == ctl.cmp_value);
    end
  end

  // append at the tail, or close a gap by shifting down
  always_ff @(posedge clk) begin
    if (ctl.append && (idx_ext == ctl.count)) begin
      entry <= ctl.app_value;
    end else if (shift_en) begin
      entry <= neighbor;
    end
  end

endmodule

FILE: rtl/ovl_first_hit.sv
// ----------------------------------------------------------------------------
// ovl_first_hit
// Finds the lowest matching cell: found flag, its index and the shift mask.
// ----------------------------------------------------------------------------
module ovl_first_hit (
  input  logic [ovl_pkg::CAPACITY-1:0] match,
  output logic                         found,
  output ovl_pkg::idx_t                position,
  output logic [ovl_pkg::CAPACITY-1:0] shift_mask  // cells at or above the hit
);

  logic [ovl_pkg::CAPACITY-1:0] below;   // cells under the first hit
  logic [ovl_pkg::CAPACITY-1:0] onehot;

  assign found      = |match;
  assign below      = (match - {{(ovl_pkg::CAPACITY-1){1'b0}}, 1'b1}) & ~match;
  assign onehot     = match & ~(match - {{(ovl_pkg::CAPACITY-1){1'b0}}, 1'b1});
  assign shift_mask = found ? ~below : '0;

  // encode the one-hot hit
  always_comb begin
    position = '0;
    for (int i = 0; i < ovl_pkg::CAPACITY; i++) begin
      if (onehot[i]) begin
        position = position | ovl_pkg::idx_t'(i);
      end
    end
  end

endmodule

FILE: rtl/ordered_value_list.sv
// ----------------------------------------------------------------------------
// ordered_value_list
// Ordered list of signed 32-bit values in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The cell row compares in the accept cycle; the first-hit resolve, the
// shift/append and the result load follow in the resolve state, and the
// result is offered once loaded. No input is accepted in the resolve state.
// A stalled result holds off the next input until it is taken.
// Reset clears the entry count, the control state and the result valid;
// the entry values themselves are not cleared.
`include "ordered_value_list_macros.svh"

module ordered_value_list (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ovl_pkg::IN_W-1:0]  s_tdata,  // [1:0] action, [33:2] operand_value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ovl_pkg::OUT_W-1:0] m_tdata   // [1:0] status, [7:2] position,
                                              // [14:8] entry_count
);

  localparam logic STATE_IDLE    = 1'b0;
  localparam logic STATE_RESOLVE = 1'b1;

  logic                         state;
  logic                         capture;
  logic                         resolve;
  ovl_pkg::action_t             op_action;
  ovl_pkg::value_t              op_value;
  ovl_pkg::cnt_t                count;
  ovl_pkg::cnt_t                count_next;
  ovl_pkg::status_t             status_next;
  ovl_pkg::idx_t                pos_next;
  ovl_pkg::cell_ctl_t           ctl;
  ovl_pkg::value_t              entry [ovl_pkg::CAPACITY];
  logic [ovl_pkg::CAPACITY-1:0] match;
  logic [ovl_pkg::CAPACITY-1:0] shift_mask;
  logic                         found;
  ovl_pkg::idx_t                hit_pos;

  assign capture  = s_tvalid && s_tready;
  assign resolve  = (state == STATE_RESOLVE);
  assign s_tready = (state == STATE_IDLE) && (!m_tvalid || m_tready);

  // broadcast controls to the cell row
  assign ctl.capture   = capture;
  assign ctl.append    = resolve && (op_action == ovl_pkg::ACT_INSERT)
                         && (count != ovl_pkg::CNT_FULL);
  assign ctl.count     = count;
  assign ctl.cmp_value = s_tdata[ovl_pkg::ACT_W +: ovl_pkg::VAL_W];
  assign ctl.app_value = op_value;

  // cell row, each cell fed by its upper neighbor
  for (genvar g = 0; g < ovl_pkg::CAPACITY; g++) begin : g_cell
    ovl_pkg::value_t upper;
    logic            shift_en;

    if (g == ovl_pkg::CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entry[g+1];
    end

    assign shift_en = resolve && (op_action == ovl_pkg::ACT_REMOVE) && shift_mask[g];

    ovl_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (ovl_pkg::idx_t'(g)),
      .shift_en (shift_en),
      .neighbor (upper),
      .entry    (entry[g]),
      .match    (match[g])
    );
  end

  ovl_first_hit u_first_hit (
    .match      (match),
    .found      (found),
    .position   (hit_pos),
    .shift_mask (shift_mask)
  );

  // action decode in the resolve cycle
  always_comb begin
    status_next = ovl_pkg::ST_OK;
    pos_next    = '0;
    count_next  = count;
    unique case (op_action)
      ovl_pkg::ACT_INSERT: begin
        if (count == ovl_pkg::CNT_FULL) begin
          status_next = ovl_pkg::ST_FULL;
        end else begin
          count_next = count + ovl_pkg::CNT_ONE;
        end
      end
      ovl_pkg::ACT_REMOVE: begin
        if (found) begin
          pos_next   = hit_pos;
          count_next = count - ovl_pkg::CNT_ONE;
        end else begin
          status_next = ovl_pkg::ST_NOT_FOUND;
        end
      end
      ovl_pkg::ACT_SEARCH: begin
        if (found) begin
          pos_next = hit_pos;
        end else begin
          status_next = ovl_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ovl_pkg::ST_OK;
      end
    endcase
  end

  // control state, count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (capture) begin
        state <= STATE_RESOLVE;
      end else if (resolve) begin
        state <= STATE_IDLE;
      end
      if (resolve) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // operand hold and result payload
  always_ff @(posedge clk) begin
    if (capture) begin
      op_action <= s_tdata[ovl_pkg::ACT_W-1:0];
      op_value  <= s_tdata[ovl_pkg::ACT_W +: ovl_pkg::VAL_W];
    end
    if (resolve) begin
      m_tdata <= ovl_pkg::OUT_W'({ovl_pkg::cnt_field_t'(count_next),
                                  ovl_pkg::pos_field_t'(pos_next),
                                  status_next});
    end
  end

  // checks
  `OVL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= ovl_pkg::CNT_FULL)
  `OVL_ASSERT_NEXT(a_accept_resolves, clk, rst, capture, state == STATE_RESOLVE)
  `OVL_ASSERT_NOW(a_no_accept_busy, clk, rst, resolve, !s_tready)
  `OVL_ASSERT_NEXT(a_remove_dec, clk, rst, resolve && (op_action == ovl_pkg::ACT_REMOVE) && found, (count + ovl_pkg::CNT_ONE) == $past(count))

endmodule
